FILE: src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hss_pkg.sv
// Types and constants of the heat stencil sweep core.
package hss_pkg;

  localparam int SAMPLE_W   = 18;
  localparam int COEF_W     = 15;
  localparam int LEN_CFG_W  = 11;
  localparam int ROWS_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAC_BITS  = 16;
  localparam int LINE_W     = 2 * SAMPLE_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = 18'sh1FFFF;
  localparam sample_t SAMPLE_MIN = 18'sh20000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF       = 2'd2;

  localparam logic [LEN_CFG_W-1:0] ROW_LENGTH_RST = 11'd1024;
  localparam logic [ROWS_W-1:0]    ROW_COUNT_RST  = 16'd1024;
  localparam logic [COEF_W-1:0]    COEF_RST       = 15'd16384;

  // five taps of the stencil around the centre point
  typedef struct packed {
    sample_t up;
    sample_t down;
    sample_t left;
    sample_t right;
    sample_t centre;
  } taps_t;

endpackage

FILE: src/heat_stencil_sweep_core.sv
// Top level of the heat stencil sweep core.
// One explicit heat-equation time step over a grid streamed in raster order,
// one sample word per cycle while in_stall is low. Each accepted sample reads
// its column from a single line store holding the two previous rows
// (registered read), so the sample is registered in an input stage; the
// stencil arithmetic then runs between that stage and the output register,
// one multiply deep. Throughput is one word per cycle while in_stall is low;
// the rate is set by the line store's single read and write per cycle. Only
// interior points give a result word; edge samples are consumed silently, and
// the last interior point carries out_last_of_grid. in_stall rises only while
// a result waits in the output register under out_stall and the input stage
// holds a point that must follow it. Writing row_length or row_count
// restarts the sweep at row 0, column 0; the coefficient takes effect at
// once. Line store contents need no clearing: rows 0 and 1 fill it before
// any result reads it.
module heat_stencil_sweep_core #(
  parameter int MAX_ROW_LENGTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hss_pkg::sample_t                  in_sample,
  // result words
  output logic                              out_valid,
  input  logic                              out_stall,
  output hss_pkg::sample_t                  out_new_value,
  output logic                              out_last_of_grid,
  // configuration
  input  logic                              cfg_we,
  input  logic [hss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int COL_W = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
  localparam int LEN_W = (COL_W + 1 > hss_pkg::LEN_CFG_W) ? COL_W + 1 : hss_pkg::LEN_CFG_W;

  // configuration
  logic [hss_pkg::LEN_CFG_W-1:0] row_length_r;
  logic [hss_pkg::ROWS_W-1:0]    row_count_r;
  logic [hss_pkg::COEF_W-1:0]    coef_r;

  // sweep position of the next word
  logic [COL_W-1:0]          col_r, col_nxt;
  logic [hss_pkg::ROWS_W-1:0] row_r, row_nxt;

  // input stage
  logic             s1_valid_r;
  hss_pkg::sample_t s1_sample_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_emit_r;
  logic             s1_last_r;

  // window taps kept from earlier words
  hss_pkg::sample_t win_up_r;     // row above, middle column
  hss_pkg::sample_t win_left_r;   // middle row, oldest column
  hss_pkg::sample_t win_centre_r; // middle row, middle column
  hss_pkg::sample_t win_down_r;   // current row, middle column

  // output register
  logic             out_valid_r;
  hss_pkg::sample_t out_value_r;
  logic             out_last_r;

  logic [LEN_W-1:0]          len_ext, len_used;
  logic [COL_W-1:0]          last_col;
  logic [hss_pkg::ROWS_W-1:0] rows_m1;
  logic                      in_acc, s1_move, out_free, geom_wr;
  logic [hss_pkg::LINE_W-1:0] line_rd;
  hss_pkg::sample_t          rd_upper, rd_middle, alu_value;
  hss_pkg::taps_t            taps;

  // clamped geometry
  always_comb begin
    len_ext = LEN_W'(row_length_r);
    if (len_ext < LEN_W'(3)) begin
      len_used = LEN_W'(3);
    end else if (len_ext > LEN_W'(MAX_ROW_LENGTH)) begin
      len_used = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      len_used = len_ext;
    end
    last_col = COL_W'(len_used - LEN_W'(1));
    rows_m1  = (row_count_r < hss_pkg::ROWS_W'(3)) ? hss_pkg::ROWS_W'(2)
                                                   : row_count_r - hss_pkg::ROWS_W'(1);
  end

  // handshake: the input stage leaves unless it holds a result that cannot
  // enter the output register
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && (!s1_emit_r || out_free);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;
  assign geom_wr  = cfg_we && (cfg_index == hss_pkg::REG_ROW_LENGTH ||
                               cfg_index == hss_pkg::REG_ROW_COUNT);

  // raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (geom_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_r == last_col) begin
        col_nxt = '0;
        row_nxt = (row_r == rows_m1) ? '0 : row_r + hss_pkg::ROWS_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  hss_line_store #(
    .DEPTH (MAX_ROW_LENGTH),
    .AW    (COL_W)
  ) u_line (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (line_rd),
    .wr_en   (s1_move),
    .wr_addr (s1_col_r),
    .wr_data ({rd_middle, s1_sample_r})
  );

  assign rd_upper  = line_rd[hss_pkg::LINE_W-1:hss_pkg::SAMPLE_W];
  assign rd_middle = line_rd[hss_pkg::SAMPLE_W-1:0];

  always_comb begin
    taps.up     = win_up_r;
    taps.down   = win_down_r;
    taps.left   = win_left_r;
    taps.centre = win_centre_r;
    taps.right  = rd_middle;
  end

  hss_stencil_alu u_alu (
    .taps      (taps),
    .coef      (coef_r),
    .new_value (alu_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= hss_pkg::ROW_LENGTH_RST;
      row_count_r  <= hss_pkg::ROW_COUNT_RST;
      coef_r       <= hss_pkg::COEF_RST;
      col_r        <= '0;
      row_r        <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      win_up_r     <= '0;
      win_left_r   <= '0;
      win_centre_r <= '0;
      win_down_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hss_pkg::REG_ROW_LENGTH: row_length_r <= cfg_data[hss_pkg::LEN_CFG_W-1:0];
          hss_pkg::REG_ROW_COUNT:  row_count_r  <= cfg_data[hss_pkg::ROWS_W-1:0];
          hss_pkg::REG_COEF:       coef_r       <= cfg_data[hss_pkg::COEF_W-1:0];
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;

      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end

      // window shifts by one column as each word leaves the input stage
      if (s1_move) begin
        win_up_r     <= rd_upper;
        win_left_r   <= win_centre_r;
        win_centre_r <= rd_middle;
        win_down_r   <= s1_sample_r;
      end

      if (s1_move && s1_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_sample;
      s1_col_r    <= col_r;
      s1_emit_r   <= (row_r >= hss_pkg::ROWS_W'(2)) && (col_r >= COL_W'(2));
      s1_last_r   <= (row_r == rows_m1) && (col_r == last_col);
    end
    if (s1_move && s1_emit_r) begin
      out_value_r <= alu_value;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_value    = out_value_r;
  assign out_last_of_grid = out_last_r;

endmodule

FILE: src/hss_line_store.sv
// Line store: one word per column holding the two previous rows.
module hss_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [hss_pkg::LINE_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [hss_pkg::LINE_W-1:0] wr_data
);

  logic [hss_pkg::LINE_W-1:0] mem [DEPTH];
  logic [hss_pkg::LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while no read is issued
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/hss_stencil_alu.sv
// Five-point stencil update with floor shift and saturation.
module hss_stencil_alu (
  input  hss_pkg::taps_t                 taps,
  input  logic [hss_pkg::COEF_W-1:0]     coef,
  output hss_pkg::sample_t               new_value
);

  logic signed [20:0] lap;
  logic signed [36:0] coef_s;
  logic signed [36:0] prod;
  logic signed [20:0] delta;
  logic signed [21:0] sum;

  always_comb begin
    lap = 21'(taps.up) + 21'(taps.down) + 21'(taps.left) + 21'(taps.right)
          - (21'(taps.centre) <<< 2);
    coef_s = 37'($signed({1'b0, coef}));
    prod   = 37'(lap) * coef_s;
    // arithmetic shift gives the floor of the product with the Q0.16 coefficient
    delta  = 21'(prod >>> hss_pkg::FRAC_BITS);
    sum    = 22'(taps.centre) + 22'(delta);
    if (sum > 22'(hss_pkg::SAMPLE_MAX)) begin
      new_value = hss_pkg::SAMPLE_MAX;
    end else if (sum < 22'(hss_pkg::SAMPLE_MIN)) begin
      new_value = hss_pkg::SAMPLE_MIN;
    end else begin
      new_value = sum[hss_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

FILE: src/hss_checker.sv
// Port-level checker for the heat stencil sweep core, with its bind.
`include "assert_macros.svh"

module hss_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input hss_pkg::sample_t out_new_value,
  input logic             out_last_of_grid
);

  `HSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_new_value) && $stable(out_last_of_grid), "result word changed while stalled")
  `HSS_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled with output free")
  `HSS_ASSERT_NOW(a_out_origin, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall, 2), "result word without input word two cycles before")
  `HSS_ASSERT_NEXT(a_reset_clear, clk, 1'b1, !rst_n, !out_valid, "result word right after reset")

endmodule

bind heat_stencil_sweep_core hss_checker u_hss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_new_value    (out_new_value),
  .out_last_of_grid (out_last_of_grid)
);
